@@ rtl/core/ted_pkg.sv @@
`default_nettype none
package ted_pkg;

   localparam int unsigned LIMIT_W = 17;
   localparam int unsigned HDR_DEPTH = 4;

   localparam logic [LIMIT_W-1:0] SCAN_LIMIT_RESET = 17'd4096;
   localparam logic [LIMIT_W-1:0] COUNT_MAX = 17'h1FFFF;

   // encoding class codes
   localparam logic [2:0] CLS_BINARY  = 3'd0;
   localparam logic [2:0] CLS_ASCII   = 3'd1;
   localparam logic [2:0] CLS_UTF8    = 3'd2;
   localparam logic [2:0] CLS_UTF16LE = 3'd3;
   localparam logic [2:0] CLS_UTF16BE = 3'd4;
   localparam logic [2:0] CLS_UTF32LE = 3'd5;
   localparam logic [2:0] CLS_UTF32BE = 3'd6;

   // byte order mark bytes
   localparam logic [7:0] BOM_00 = 8'h00;
   localparam logic [7:0] BOM_EF = 8'hEF;
   localparam logic [7:0] BOM_BB = 8'hBB;
   localparam logic [7:0] BOM_BF = 8'hBF;
   localparam logic [7:0] BOM_FE = 8'hFE;
   localparam logic [7:0] BOM_FF = 8'hFF;

   typedef logic [HDR_DEPTH-1:0][7:0] header_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] count;
      logic               null_seen;
      logic               all_ascii;
      logic               utf8_valid;
      logic [1:0]         cont_left;
   } scan_state_type;

endpackage
`default_nettype wire

@@ rtl/core/ted_if.sv @@
`default_nettype none
interface ted_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_stream;

   modport source (output valid, data_byte, byte_present, end_of_stream, input ready);
   modport sink (input valid, data_byte, byte_present, end_of_stream, output ready);
endinterface

interface ted_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] encoding_class;

   modport source (output valid, encoding_class, input ready);
   modport sink (input valid, encoding_class, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ted_classify.sv @@
`default_nettype none
module ted_classify (
   input  ted_pkg::scan_state_type st,
   input  ted_pkg::header_type     header,
   output logic [2:0]              encoding_class
);

   logic ge2, ge3, ge4;

   assign ge2 = st.count >= ted_pkg::LIMIT_W'(2);
   assign ge3 = st.count >= ted_pkg::LIMIT_W'(3);
   assign ge4 = st.count >= ted_pkg::LIMIT_W'(4);

   always_comb begin
      if (ge2 && header[0] == ted_pkg::BOM_FF && header[1] == ted_pkg::BOM_FE) begin
         if (ge4 && header[2] == ted_pkg::BOM_00 && header[3] == ted_pkg::BOM_00)
            encoding_class = ted_pkg::CLS_UTF32LE;
         else
            encoding_class = ted_pkg::CLS_UTF16LE;
      end else if (ge2 && header[0] == ted_pkg::BOM_FE && header[1] == ted_pkg::BOM_FF) begin
         encoding_class = ted_pkg::CLS_UTF16BE;
      end else if (ge3 && header[0] == ted_pkg::BOM_EF && header[1] == ted_pkg::BOM_BB &&
                   header[2] == ted_pkg::BOM_BF) begin
         encoding_class = ted_pkg::CLS_UTF8;
      end else if (ge4 && header[0] == ted_pkg::BOM_00 && header[1] == ted_pkg::BOM_00 &&
                   header[2] == ted_pkg::BOM_FE && header[3] == ted_pkg::BOM_FF) begin
         encoding_class = ted_pkg::CLS_UTF32BE;
      end else if (st.null_seen) begin
         encoding_class = ted_pkg::CLS_BINARY;
      end else if (st.all_ascii) begin
         encoding_class = ted_pkg::CLS_ASCII;
      end else if (st.utf8_valid && st.cont_left == 2'd0) begin
         encoding_class = ted_pkg::CLS_UTF8;
      end else begin
         encoding_class = ted_pkg::CLS_BINARY;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/ted_scan.sv @@
`default_nettype none
module ted_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [7:0]                   data_byte,
   input  logic                         byte_present,
   input  logic                         end_of_stream,
   input  logic [ted_pkg::LIMIT_W-1:0]  scan_limit,
   output logic [2:0]                   encoding_class
);

   localparam ted_pkg::scan_state_type STATE_CLEAR = '{
      count: '0, null_seen: 1'b0, all_ascii: 1'b1, utf8_valid: 1'b1, cont_left: 2'd0
   };

   ted_pkg::scan_state_type state_ff, state_in, upd;
   ted_pkg::header_type     header_ff, header_in;
   logic                    take;

   assign take = step && byte_present;

   always_comb begin
      upd = state_ff;
      header_in = header_ff;
      if (take) begin
         if (state_ff.count < ted_pkg::LIMIT_W'(ted_pkg::HDR_DEPTH))
            header_in[state_ff.count[1:0]] = data_byte;
         if (state_ff.count < scan_limit) begin
            if (data_byte == 8'h00)
               upd.null_seen = 1'b1;
            if (data_byte[7])
               upd.all_ascii = 1'b0;
            if (state_ff.cont_left != 2'd0) begin
               if (data_byte[7:6] != 2'b10)
                  upd.utf8_valid = 1'b0;
               upd.cont_left = state_ff.cont_left - 2'd1;
            end else if (data_byte[7]) begin
               // lead byte sets how many continuation bytes follow
               if (data_byte[7:5] == 3'b110)
                  upd.cont_left = 2'd1;
               else if (data_byte[7:4] == 4'b1110)
                  upd.cont_left = 2'd2;
               else if (data_byte[7:3] == 5'b11110)
                  upd.cont_left = 2'd3;
               else
                  upd.utf8_valid = 1'b0;
            end
         end
         if (state_ff.count != ted_pkg::COUNT_MAX)
            upd.count = state_ff.count + ted_pkg::LIMIT_W'(1);
      end
      state_in = (step && end_of_stream) ? STATE_CLEAR : upd;
   end

   ted_classify u_classify (
      .st             (upd),
      .header         (header_in),
      .encoding_class (encoding_class)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // header bytes are read only where written in the current stream
   always_ff @(posedge clock) begin
      header_ff <= header_in;
   end

endmodule
`default_nettype wire

@@ rtl/core/text_encoding_detector.sv @@
// Text encoding detector.
// req_bus carries one stream byte per item (data_byte, byte_present) and
// marks the last item with end_of_stream; a bare end marker has
// byte_present low. For each end item one encoding_class leaves on rsp_bus:
// 0 binary, 1 ascii, 2 utf8, 3 utf16le, 4 utf16be, 5 utf32le, 6 utf32be.
// csr_write_enable/csr_write_data set scan_limit, the number of leading bytes
// the content scan examines; write it only between streams.
// An accepted end item enters the input register, then passes the
// scan/classify update into the result register, where its result is valid.
// Items are taken at one item per cycle while req_bus.ready is high; the
// scan flags and byte counter update as each item leaves the input register.
// When rsp_bus stalls, byte items keep flowing; an end item waits in the
// input register and req_bus.ready drops only while a result is held and
// another end item is waiting behind it.
// Reset clears the pipeline, the stream state and sets scan_limit to 4096.
`default_nettype none
module text_encoding_detector (
   input  logic                        clock,
   input  logic                        reset,
   ted_req_if.sink                     req_bus,
   ted_rsp_if.source                   rsp_bus,
   input  logic                        csr_write_enable,
   input  logic [ted_pkg::LIMIT_W-1:0] csr_write_data
);

   logic                        s1_valid_ff, s1_valid_in;
   logic [7:0]                  s1_byte_ff;
   logic                        s1_present_ff, s1_last_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [2:0]                  rsp_class_ff, class_in;
   logic [ted_pkg::LIMIT_W-1:0] scan_limit_ff;
   logic                        stall, advance, accept;

   // hold an end item while the result register is occupied and not taken
   assign stall   = s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_bus.ready;
   assign advance = s1_valid_ff && !stall;
   assign req_bus.ready = !stall;
   assign accept  = req_bus.valid && !stall;

   assign s1_valid_in  = accept || stall;
   assign rsp_valid_in = (advance && s1_last_ff) || (rsp_valid_ff && !rsp_bus.ready);

   ted_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .data_byte      (s1_byte_ff),
      .byte_present   (s1_present_ff),
      .end_of_stream  (s1_last_ff),
      .scan_limit     (scan_limit_ff),
      .encoding_class (class_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         scan_limit_ff <= ted_pkg::SCAN_LIMIT_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable)
            scan_limit_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff    <= req_bus.data_byte;
         s1_present_ff <= req_bus.byte_present;
         s1_last_ff    <= req_bus.end_of_stream;
      end
      if (advance && s1_last_ff)
         rsp_class_ff <= class_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.encoding_class = rsp_class_ff;

endmodule
`default_nettype wire

@@ rtl/core/ted_checker.sv @@
`default_nettype none
module ted_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_class
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_class))
      else $error("stalled result changed");

   // the input backs up only behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a held result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_class <= ted_pkg::CLS_UTF32BE)
      else $error("encoding class out of range");

endmodule

bind text_encoding_detector ted_checker u_ted_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_class (rsp_bus.encoding_class)
);
`default_nettype wire
